// File: src/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SITDA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SITDA_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: src/sitda_pkg.sv
// Types, constants and helper functions for the signed integer to decimal ASCII block.
// No dependencies; imported by every module of the block.
package sitda_pkg;

   localparam int VALUE_W    = 32;
   localparam int NUM_DIGITS = 10;
   localparam int DIGIT_W    = 4;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = 4;
   localparam int STEP_W     = 5;

   localparam logic [STEP_W-1:0]  LAST_STEP    = STEP_W'(VALUE_W - 1);
   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_BIAS  = 4'd3;
   localparam logic [DIGIT_W-1:0] RADIX        = 4'd10;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 8'd48;
   localparam logic [CHAR_W-1:0]  ASCII_MINUS  = 8'd45;

   typedef struct packed {
      logic             negative;
      logic [BCD_W-1:0] bcd;
   } sitda_word_type;

   // Number of significant decimal digits; zero counts as one digit.
   function automatic logic [COUNT_W-1:0] digit_count(input logic [BCD_W-1:0] bcd);
      logic [COUNT_W-1:0] n;
      n = COUNT_W'(1);
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
            n = COUNT_W'(i + 1);
         end
      end
      return n;
   endfunction

   // True when every digit of a packed BCD value is a decimal digit.
   function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd[i*DIGIT_W +: DIGIT_W] >= RADIX) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

// File: src/sitda_dabble.sv
// Bit-serial binary to BCD converter (shift and add-three), one magnitude bit per cycle.
// Depends on sitda_pkg.
module sitda_dabble import sitda_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      hand_valid,
   input  logic                      hand_ready,
   output sitda_word_type            hand_word
);

   typedef enum logic [1:0] {IDLE, CONVERT, HOLD} state_type;

   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic                 neg_ff, neg_in;
   logic [BCD_W-1:0]     bcd_adj;
   logic [VALUE_W-1:0]   value_bits;

   assign value_bits = $unsigned(req_value);

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + DABBLE_BIAS;
         end else begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               neg_in   = value_bits[VALUE_W-1];
               mag_in   = value_bits[VALUE_W-1] ? (VALUE_W'(0) - value_bits) : value_bits;
               bcd_in   = '0;
               step_in  = '0;
               state_in = CONVERT;
            end
         end
         CONVERT: begin
            bcd_in  = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
            mag_in  = {mag_ff[VALUE_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = HOLD;
            end
         end
         HOLD: begin
            if (hand_ready) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
   end

   assign req_stall          = (state_ff != IDLE);
   assign hand_valid         = (state_ff == HOLD);
   assign hand_word.negative = neg_ff;
   assign hand_word.bcd      = bcd_ff;

endmodule

// File: src/sitda_emit.sv
// Character emitter: sign, then significant digits most significant first, through an output register.
// Depends on sitda_pkg.
module sitda_emit import sitda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               hand_valid,
   output logic               hand_ready,
   input  sitda_word_type     hand_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_character,
   output logic               rsp_last
);

   logic                sign_ff, sign_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [DIGIT_W-1:0]  digit_ff [NUM_DIGITS];
   logic [DIGIT_W-1:0]  digit_in [NUM_DIGITS];
   logic                valid_ff, valid_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic                busy;
   logic                advance;
   logic [COUNT_W-1:0]  sel;

   assign busy       = sign_ff || (rem_ff != '0);
   assign hand_ready = !busy;
   assign advance    = !valid_ff || !rsp_stall;
   assign sel        = rem_ff - COUNT_W'(1);

   always_comb begin
      sign_in  = sign_ff;
      rem_in   = rem_ff;
      digit_in = digit_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = busy;
         if (sign_ff) begin
            char_in = ASCII_MINUS;
            last_in = 1'b0;
            sign_in = 1'b0;
         end else if (busy) begin
            char_in = ASCII_ZERO + CHAR_W'(digit_ff[sel]);
            last_in = (rem_ff == COUNT_W'(1));
            rem_in  = sel;
         end
      end
      if (!busy && hand_valid) begin
         sign_in = hand_word.negative;
         rem_in  = digit_count(hand_word.bcd);
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_in[i] = hand_word.bcd[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_ff  <= 1'b0;
         rem_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sign_ff  <= sign_in;
         rem_ff   <= rem_in;
         valid_ff <= valid_in;
      end
      digit_ff <= digit_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// File: src/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text. Each accepted word yields its characters,
// most significant first: a leading '-' for negative values, no leading zeros, '0' for
// zero, and rsp_last high on the final character. Each word passes through the
// bit-serial BCD converter (an accept step, 32 shift-and-add-three steps, one handoff);
// the converter takes no new word until its handoff. Characters leave at one per cycle
// from an output register while the next word converts, unless the result side stalls.
// Depends on sitda_pkg, sitda_dabble, sitda_emit and assert_macros.svh.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii import sitda_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CHAR_W-1:0]         rsp_character,
   output logic                      rsp_last
);

   logic           hand_valid;
   logic           hand_ready;
   sitda_word_type hand_word;

   sitda_dabble u_dabble (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .hand_valid (hand_valid),
      .hand_ready (hand_ready),
      .hand_word  (hand_word)
   );

   sitda_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .hand_valid    (hand_valid),
      .hand_ready    (hand_ready),
      .hand_word     (hand_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   `SITDA_IMPLY(a_bcd_digits, hand_valid, bcd_ok(hand_word.bcd), "non-decimal BCD digit")
   `SITDA_ASSERT(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall, "not busy")
   `SITDA_ASSERT(a_hand_hold, hand_valid && !hand_ready |=> hand_valid && $stable(hand_word), "word lost")
   `SITDA_IMPLY(a_minus_not_last, rsp_valid && (rsp_character == ASCII_MINUS), !rsp_last, "sign last")

endmodule

// File: bench/decimal_text_checker.sv
// Checker for signed_int_to_decimal_ascii: watches both channels, predicts the decimal
// text of every accepted word and compares each character and last flag in order.
// Depends on sitda_pkg for widths and the ASCII codes.
module decimal_text_checker import sitda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [CHAR_W-1:0]  rsp_character,
   input  logic               rsp_last,
   output int                 mismatch_count,
   output int                 chars_pending,
   output int                 chars_checked
);

   localparam int DECIMAL_BASE = 10;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   text_char_type expected_text[$];

   function automatic void predict_text(input logic [VALUE_W-1:0] bits);
      logic [VALUE_W-1:0] magnitude;
      logic [DIGIT_W-1:0] digits [NUM_DIGITS];
      int                 n;
      text_char_type      c;
      magnitude = bits[VALUE_W-1] ? (~bits + 1'b1) : bits;
      n = 0;
      do begin
         digits[n] = DIGIT_W'(magnitude % DECIMAL_BASE);
         magnitude = magnitude / DECIMAL_BASE;
         n++;
      end while (magnitude != 0 && n < NUM_DIGITS);
      if (bits[VALUE_W-1]) begin
         c.code = ASCII_MINUS;
         c.last = 1'b0;
         expected_text.push_back(c);
      end
      for (int k = n - 1; k >= 0; k--) begin
         c.code = ASCII_ZERO + CHAR_W'(digits[k]);
         c.last = (k == 0);
         expected_text.push_back(c);
      end
   endfunction

   always @(posedge clock) begin : watch
      text_char_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected character 0x%h last=%0d with nothing pending",
                           rsp_character, rsp_last);
               end
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.code || rsp_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("character mismatch: expected 0x%h last=%0d, got 0x%h last=%0d",
                              want.code, want.last, rsp_character, rsp_last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_text(req_value);
         end
         chars_pending = expected_text.size();
      end
   end

endmodule

// File: bench/testbench.sv
// Top of the bench for signed_int_to_decimal_ascii: drives corner and random words
// under several idling mixes and gives the verdict from decimal_text_checker.
// Depends on sitda_pkg, the block and decimal_text_checker.
module testbench;
   import sitda_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int WORDS_PER_MIX = 38;
   localparam int DRAIN_CYCLES  = 50;

   localparam logic [VALUE_W-1:0] CORNER_VALUES [20] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      -32'sd100, 32'd999999999, 32'd1000000000, -32'sd1000000000, 32'h7FFF_FFFF,
      32'h8000_0001, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789,
      -32'sd987654321
   };
   localparam int SEND_IDLE [4]  = '{0, 70, 0, 32};
   localparam int RECV_STALL [4] = '{0, 0, 70, 32};

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [CHAR_W-1:0]         rsp_character;
   logic                      rsp_last;

   int mismatch_count;
   int chars_pending;
   int chars_checked;
   int send_idle_pct;
   int recv_stall_pct;
   int values_sent;
   int cycle_count;

   signed_int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   decimal_text_checker text_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending),
      .chars_checked  (chars_checked)
   );

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_value      = '0;
      rsp_stall      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      values_sent    = 0;
      cycle_count    = 0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit with %0d characters pending", chars_pending);
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] scale;
      logic [VALUE_W-1:0] v;
      int                 k;
      scale = 1;
      k = $urandom_range(NUM_DIGITS - 1);
      for (int i = 0; i < k; i++) begin
         scale = scale * 10;
      end
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = scale - $urandom_range(1);
         2: v = $urandom % scale;
         default: v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(15)
                                        : 32'h7FFF_FFFF - $urandom_range(15);
      endcase
      if (k != 0 && $urandom_range(1)) begin
         v = ~v + 1'b1;
      end
      return v;
   endfunction

   task automatic send_value(input logic [VALUE_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
      values_sent++;
   endtask

   task automatic drain_text();
      req_valid <= 1'b0;
      while (chars_pending != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (CORNER_VALUES[i]) begin
         send_value(CORNER_VALUES[i]);
      end
      drain_text();

      for (int m = 0; m < 4; m++) begin
         send_idle_pct  = SEND_IDLE[m];
         recv_stall_pct = RECV_STALL[m];
         repeat (WORDS_PER_MIX) begin
            send_value(pick_value());
         end
         drain_text();
      end

      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d words converted, %0d characters checked: corners, then random words",
               values_sent, chars_checked);
      $display("under no idling, sender gaps, receiver stalls and both together");
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches, %0d characters never arrived", mismatch_count,
                  chars_pending);
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
